@@ hdl/pjf_pkg.sv @@
package pjf_pkg;

    // Field widths fixed by the item formats.
    localparam int CH_W    = 4;
    localparam int RAW_W   = 10;
    localparam int LEVEL_W = 7;
    localparam int CNT_W   = 8;
    localparam int CC_W    = 7;

    // Scaling ratio: level = floor(raw * SCALE_NUM / SCALE_DEN).
    localparam int SCALE_NUM = 127;
    localparam int SCALE_DEN = 1023;
    localparam int PROD_W    = RAW_W + LEVEL_W;

    // Register file.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CC_W-1:0]  BASE_CONTROLLER_RST = 7'd70;
    localparam logic [CNT_W-1:0] BOUNCE_LIMIT_RST    = 8'd4;
    localparam logic [CNT_W-1:0] CNT_MAX             = 8'd255;

    typedef enum logic {
        REG_BASE_CONTROLLER = 1'b0,
        REG_BOUNCE_LIMIT    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CH_W-1:0]  channel_index;
        logic [RAW_W-1:0] raw_sample;
    } t_in_item;

    typedef struct packed {
        logic [CC_W-1:0]    controller_number;
        logic [LEVEL_W-1:0] controller_value;
    } t_out_item;

    typedef struct packed {
        logic [CC_W-1:0]  base_controller;
        logic [CNT_W-1:0] bounce_limit;
    } t_cfg;

    typedef struct packed {
        logic in_range;
        logic changed;
        logic emit;
    } t_filt_status;

    // raw * 127 / 1023 without a divider: 1/1023 ~ (1 + 1/1024) / 1024, which
    // never overshoots and is at most one short, so one compare fixes it.
    function automatic logic [LEVEL_W-1:0] scale_level(input logic [RAW_W-1:0] raw);
        logic [PROD_W-1:0]  prod;
        logic [PROD_W-1:0]  approx;
        logic [LEVEL_W-1:0] q0;
        logic [PROD_W-1:0]  rem;
        prod   = {raw, 7'b0} - PROD_W'(raw);
        approx = prod + PROD_W'(prod[PROD_W-1:10]);
        q0     = approx[PROD_W-1:10];
        rem    = prod - ({q0, 10'b0} - PROD_W'(q0));
        if (rem >= PROD_W'(SCALE_DEN)) begin
            return q0 + LEVEL_W'(1);
        end
        return q0;
    endfunction

endpackage

@@ hdl/pjf_cfg_regs.sv @@
module pjf_cfg_regs
    import pjf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_controller <= BASE_CONTROLLER_RST;
            r_cfg.bounce_limit    <= BOUNCE_LIMIT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BASE_CONTROLLER: r_cfg.base_controller <= pwdata[CC_W-1:0];
                REG_BOUNCE_LIMIT:    r_cfg.bounce_limit    <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_BASE_CONTROLLER: prdata = APB_DATA_W'(r_cfg.base_controller);
            REG_BOUNCE_LIMIT:    prdata = APB_DATA_W'(r_cfg.bounce_limit);
            default:             prdata = '0;
        endcase
    end

endmodule

@@ hdl/pjf_chan_filter.sv @@
module pjf_chan_filter
    import pjf_pkg::*;
#(
    parameter int NUM_CHANNELS = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_advance,
    input  logic [CH_W-1:0]    i_channel,
    input  logic [LEVEL_W-1:0] i_level,
    input  logic [CNT_W-1:0]   i_limit,
    output t_filt_status       o_status
);

    // Only channels reachable through the index field need storage.
    localparam int DEPTH = (NUM_CHANNELS < (1 << CH_W)) ? NUM_CHANNELS : (1 << CH_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CH_W:0] DEPTH_LIM = (CH_W + 1)'(DEPTH);

    logic [LEVEL_W-1:0] r_last  [DEPTH];
    logic [LEVEL_W-1:0] r_older [DEPTH];
    logic [CNT_W-1:0]   r_count [DEPTH];

    logic [IDX_W-1:0]   idx;
    logic [LEVEL_W-1:0] last_lvl;
    logic [LEVEL_W-1:0] older_lvl;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   n_count;
    logic               wr_en;

    assign idx       = i_channel[IDX_W-1:0];
    assign last_lvl  = r_last[idx];
    assign older_lvl = r_older[idx];
    assign count     = r_count[idx];

    always_comb begin
        o_status.in_range = ({1'b0, i_channel} < DEPTH_LIM);
        o_status.changed  = (i_level != last_lvl);
        if (i_level == older_lvl) begin
            n_count = (count == CNT_MAX) ? CNT_MAX : count + CNT_W'(1);
        end else begin
            n_count = '0;
        end
        o_status.emit = i_valid && o_status.in_range && o_status.changed
                        && (n_count <= i_limit);
    end

    assign wr_en = i_valid && i_advance && o_status.in_range && o_status.changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_last[k]  <= '0;
                r_older[k] <= '0;
                r_count[k] <= '0;
            end
        end else if (wr_en) begin
            r_last[idx]  <= i_level;
            r_older[idx] <= last_lvl;
            r_count[idx] <= n_count;
        end
    end

endmodule

@@ hdl/pot_jitter_filter_to_cc_unit.sv @@
// Potentiometer jitter filter to control-change messages. Each input
// transaction carries a 10-bit converter sample and the potentiometer's
// channel index; the sample is scaled to 7 bits (raw * 127 / 1023) and
// compared with that channel's history. A value equal to the last one is
// dropped silently; a value that flips back to the one before counts as a
// bounce, and once a channel's bounce count exceeds bounce_limit it stops
// reporting until it moves somewhere new. Reported values leave as one
// output transaction holding base_controller + channel (mod 128) and the
// scaled level. Channel indices at or above NUM_CHANNELS are ignored.
// Throughput is one transaction per clock while the output is not stalled;
// each sample passes the input register and then the result register. The
// per-channel history is read and written in the same cycle from the input
// register, so consecutive samples of one channel need no forwarding. A stall
// on the output holds the input register, and with it the input side, until
// the result is taken.
// Registers: base_controller at byte address 0, bounce_limit at address 4.
module pot_jitter_filter_to_cc_unit
    import pjf_pkg::*;
#(
    parameter int NUM_CHANNELS = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg         cfg;
    t_filt_status status;

    // Input register
    logic         r_in_valid;
    t_in_item     r_in;
    // Result register
    logic         r_out_valid;
    t_out_item    r_out;

    logic               advance;
    logic [LEVEL_W-1:0] level;

    pjf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Scale the held sample; a short constant multiply and one correction.
    assign level = scale_level(r_in.raw_sample);

    pjf_chan_filter #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_chan_filter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .i_advance (advance),
        .i_channel (r_in.channel_index),
        .i_level   (level),
        .i_limit   (cfg.bounce_limit),
        .o_status  (status)
    );

    // The held item moves on whenever the result register is free or
    // being emptied this cycle.
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= status.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && status.emit) begin
            r_out.controller_number <= cfg.base_controller
                                       + CC_W'(r_in.channel_index);
            r_out.controller_value  <= level;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hdl/pjf_checker.sv @@
module pjf_checker
    import pjf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A fresh result needs an input transaction accepted before it.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without a matching input transaction");

    // An empty output side never blocks the input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with output empty");

endmodule

bind pot_jitter_filter_to_cc_unit pjf_checker u_pjf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ dv/pjf_cc_checker.sv @@
`timescale 1ns / 1ps

module pjf_cc_checker
    import pjf_pkg::*;
#(
    parameter int NUM_CHANNELS = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,

    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,

    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,

    output int                    o_pending,
    output int                    o_checked,
    output int                    o_errors
);

    logic [LEVEL_W-1:0] last_lvl [NUM_CHANNELS];
    logic [LEVEL_W-1:0] prev_lvl [NUM_CHANNELS];
    logic [CNT_W-1:0]   flips    [NUM_CHANNELS];
    t_cfg               cfg;
    t_out_item          cc_expected[$];
    int                 errors  = 0;
    int                 checked = 0;

    assign o_errors  = errors;
    assign o_checked = checked;

    task automatic flag_error(input string msg);
        $display("[%0t] cc mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // Filter one sample through the per-channel history; 1 when a message is due.
    function automatic bit predict_cc(input t_in_item item, output t_out_item cc);
        int unsigned        ch;
        logic [LEVEL_W-1:0] level;
        ch = item.channel_index;
        cc = '0;
        if (ch >= NUM_CHANNELS) begin
            return 1'b0;
        end
        level = LEVEL_W'((int'(item.raw_sample) * SCALE_NUM) / SCALE_DEN);
        if (level == last_lvl[ch]) begin
            return 1'b0;
        end
        if (level == prev_lvl[ch]) begin
            if (flips[ch] != CNT_MAX) begin
                flips[ch] = flips[ch] + 1'b1;
            end
        end else begin
            flips[ch] = '0;
        end
        prev_lvl[ch] = last_lvl[ch];
        last_lvl[ch] = level;
        if (flips[ch] > cfg.bounce_limit) begin
            return 1'b0;
        end
        cc.controller_number = CC_W'(cfg.base_controller + ch);
        cc.controller_value  = level;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                last_lvl[k] = '0;
                prev_lvl[k] = '0;
                flips[k]    = '0;
            end
            cfg.base_controller = BASE_CONTROLLER_RST;
            cfg.bounce_limit    = BOUNCE_LIMIT_RST;
            cc_expected.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[1:0] == 2'b00) begin
                case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                    REG_BASE_CONTROLLER: cfg.base_controller = i_pwdata[CC_W-1:0];
                    REG_BOUNCE_LIMIT:    cfg.bounce_limit    = i_pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (cc_expected.size() == 0) begin
                    flag_error($sformatf("unexpected result, number %0d value %0d",
                                         got.controller_number, got.controller_value));
                end else begin
                    want = cc_expected.pop_front();
                    checked++;
                    if (got.controller_number !== want.controller_number) begin
                        flag_error($sformatf("controller_number %0d, expected %0d",
                                             got.controller_number, want.controller_number));
                    end
                    if (got.controller_value !== want.controller_value) begin
                        flag_error($sformatf("controller_value %0d, expected %0d",
                                             got.controller_value, want.controller_value));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (predict_cc(i_in_data, want)) begin
                    cc_expected.push_back(want);
                end
            end
        end
        o_pending <= cc_expected.size();
    end

endmodule

@@ dv/tb_pot_jitter_filter_to_cc_unit.sv @@
`timescale 1ns / 1ps

module tb_pot_jitter_filter_to_cc_unit;
    import pjf_pkg::*;

    localparam int NUM_CHANNELS     = 9;
    localparam int PHASES           = 6;    // register settings after the reset one
    localparam int RANDOM_PER_PHASE = 185;  // in-range samples per setting
    localparam int TOGGLE_RUN       = 270;  // long enough to saturate a bounce counter
    localparam int SETTLE_CYCLES    = 6;    // pipeline is two deep; leave margin
    localparam int DRAIN_LIMIT      = 2000;

    // Drive every input to a known value from time zero.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int cc_pending;
    int cc_checked;
    int cc_errors;

    bit gaps_on      = 1'b0;
    int stall_left   = 0;
    int samples_sent = 0;

    // Per-channel pair of raw readings to bounce between, and the last reading sent.
    logic [RAW_W-1:0] pair_a   [NUM_CHANNELS];
    logic [RAW_W-1:0] pair_b   [NUM_CHANNELS];
    bit               pair_side[NUM_CHANNELS];
    logic [RAW_W-1:0] last_raw [NUM_CHANNELS];

    always #5 i_clk = ~i_clk;

    pot_jitter_filter_to_cc_unit #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pjf_cc_checker #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_pending   (cc_pending),
        .o_checked   (cc_checked),
        .o_errors    (cc_errors)
    );

    // Receiver side: hold ready low in random bursts while gaps are on,
    // otherwise accept every cycle.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Offer one sample and hold it until the block takes it. Entered just after a
    // rising edge; returns at the edge of acceptance without touching valid again,
    // so the next call (or the drain) is the only one to drive it in that step.
    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [RAW_W-1:0] raw);
        t_in_item item;
        item.channel_index = ch;
        item.raw_sample    = raw;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        if (ch < NUM_CHANNELS) begin
            samples_sent++;
            last_raw[ch] = raw;
        end
    endtask

    // Drop valid, wait for every expected message, then let the pipeline empty of
    // samples that produce nothing before the registers may change.
    task automatic quiesce();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (cc_pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Two-phase register write: setup, then access until pready.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly bounce between two readings per channel so the counters climb and
    // suppression kicks in; the rest is fresh readings, repeats that scale to the
    // same level, scaling edges, and out-of-range channels.
    task automatic random_sample();
        int               pick;
        int               ch;
        logic [RAW_W-1:0] raw;
        pick = $urandom_range(0, 99);
        ch   = $urandom_range(0, NUM_CHANNELS - 1);
        if (pick < 55) begin
            if ($urandom_range(0, 15) == 0) begin
                pair_a[ch] = RAW_W'($urandom);
                pair_b[ch] = RAW_W'($urandom);
            end
            pair_side[ch] = !pair_side[ch];
            raw = pair_side[ch] ? pair_a[ch] : pair_b[ch];
        end else if (pick < 75) begin
            raw = RAW_W'($urandom);
        end else if (pick < 85) begin
            raw = last_raw[ch];
        end else if (pick < 95) begin
            case ($urandom_range(0, 3))
                0:       raw = '0;
                1:       raw = '1;
                2:       raw = RAW_W'($urandom_range(1, 9));
                default: raw = RAW_W'($urandom_range(1014, 1022));
            endcase
        end else begin
            ch  = $urandom_range(NUM_CHANNELS, 2**CH_W - 1);
            raw = RAW_W'($urandom);
        end
        send_sample(CH_W'(ch), raw);
    endtask

    initial begin
        int               target;
        bit               tog;
        logic [CC_W-1:0]  base;
        logic [CNT_W-1:0] limit;

        tog = 1'b0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            pair_a[k]    = RAW_W'($urandom);
            pair_b[k]    = RAW_W'($urandom);
            pair_side[k] = 1'b0;
            last_raw[k]  = '0;
        end

        // Hold reset from time zero, then release it once.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gaps_on <= 1'b1;

        // Directed pass on the reset settings (base 70, bounce limit 4).
        send_sample(4'd0, 10'd1023);    // full scale, first report
        send_sample(4'd0, 10'd1023);    // same level, dropped
        send_sample(4'd0, 10'd0);       // flip back: bounces start counting
        send_sample(4'd0, 10'd1023);
        send_sample(4'd0, 10'd0);
        send_sample(4'd0, 10'd1023);
        send_sample(4'd0, 10'd0);       // counter now above the limit: muted
        send_sample(4'd0, 10'd1023);
        send_sample(4'd0, 10'd0);
        send_sample(4'd0, 10'd500);     // new level clears the counter
        send_sample(4'd1, 10'd8);       // still scales to zero, dropped
        send_sample(4'd1, 10'd9);       // first reading that scales to one
        send_sample(4'd2, 10'd1014);    // just under a step
        send_sample(4'd2, 10'd1015);    // just on a step
        send_sample(4'd2, 10'd1022);    // same level as before, dropped
        send_sample(4'd8, 10'd512);     // top channel
        send_sample(4'd9, 10'd700);     // out of range, ignored
        send_sample(4'd15, 10'd1023);   // out of range, ignored
        send_sample(4'd7, 10'h2AA);
        send_sample(4'd5, 10'h155);

        for (int ph = 0; ph < PHASES; ph++) begin
            quiesce();
            case (ph)
                0:       begin base = 7'd119; limit = 8'd0;   end
                1:       begin base = 7'd0;   limit = 8'd254; end
                2:       begin base = 7'd127; limit = 8'd255; end  // number wraps
                3:       begin base = CC_W'($urandom); limit = CNT_W'($urandom); end
                4:       begin base = 7'd33;  limit = 8'd1;   end
                default: begin base = BASE_CONTROLLER_RST; limit = BOUNCE_LIMIT_RST; end
            endcase
            write_reg(REG_BASE_CONTROLLER, APB_DATA_W'(base));
            write_reg(REG_BOUNCE_LIMIT, APB_DATA_W'(limit));
            // Every third setting runs without gaps, the last one among them.
            gaps_on <= (ph % 3) != 2;

            // Hammer one channel past counter saturation: with a limit of 254 it
            // goes quiet at 255, with 255 it never does.
            if (ph == 1 || ph == 2) begin
                repeat (TOGGLE_RUN) begin
                    tog = !tog;
                    send_sample(4'd3, tog ? 10'd1023 : 10'd0);
                end
            end

            target = samples_sent + RANDOM_PER_PHASE;
            while (samples_sent < target) begin
                random_sample();
            end
        end

        quiesce();
        $display("Covered %0d in-range samples over %0d register settings; %0d messages matched.",
                 samples_sent, PHASES + 1, cc_checked);
        if (cc_errors == 0 && cc_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
